// ===== src/bpfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;

	localparam int unsigned MaxPagesDef = 65536;

	localparam int WordBits = 64;
	localparam int BitW     = 6;
	localparam int CountW   = 17;
	localparam int PageW    = 18;
	localparam int WidxW    = PageW - BitW;
	localparam int PopW     = BitW + 1;

	localparam logic [CountW-1:0] CountMax = '1;

	// Action codes
	localparam logic [2:0] ActFree    = 3'd0;
	localparam logic [2:0] ActLock    = 3'd1;
	localparam logic [2:0] ActReserve = 3'd2;
	localparam logic [2:0] ActRelease = 3'd3;
	localparam logic [2:0] ActRequest = 3'd4;

	// Status codes
	localparam logic [1:0] StDone   = 2'd0;
	localparam logic [1:0] StNoFree = 2'd1;
	localparam logic [1:0] StRange  = 2'd2;

	typedef struct packed {
		logic [2:0]      action;
		logic [BitW-1:0] lo;
		logic [BitW-1:0] hi;
	} bpfa_ctrl_t;

	typedef struct packed {
		logic [WordBits-1:0] new_word;
		logic [PopW-1:0]     changed;
		logic                found;
		logic [BitW-1:0]     bit_idx;
	} bpfa_res_t;

	function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] v,
			input logic [PopW-1:0] n);
		logic [CountW:0] s;
		s = {1'b0, v} + (CountW+1)'(n);
		return s[CountW] ? CountMax : s[CountW-1:0];
	endfunction

	function automatic logic [CountW-1:0] sat_sub(input logic [CountW-1:0] v,
			input logic [PopW-1:0] n);
		return (v > CountW'(n)) ? v - CountW'(n) : '0;
	endfunction

endpackage
`default_nettype wire

// ===== src/bpfa_word_ops.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpfa_word_ops import bpfa_pkg::*; (
	input  logic [WordBits-1:0] word,
	input  bpfa_ctrl_t          ctrl,
	output bpfa_res_t           res
);

	logic [WordBits-1:0] mask;
	logic [WordBits-1:0] avail;
	logic [WordBits-1:0] pick;
	logic [WordBits-1:0] change;
	logic [WordBits-1:0] new_w;
	logic [PopW-1:0]     pop;
	logic [BitW-1:0]     idx;
	logic                set_op;
	logic [1:0]          p1 [32];
	logic [2:0]          p2 [16];
	logic [3:0]          p3 [8];
	logic [4:0]          p4 [4];
	logic [5:0]          p5 [2];

	always_comb begin
		mask  = ({WordBits{1'b1}} << ctrl.lo) & ({WordBits{1'b1}} >> (6'd63 - ctrl.hi));
		avail = ~word & mask;
		// isolate the lowest clear page
		pick  = avail & (~avail + 64'd1);
		idx   = '0;
		for (int b = 0; b < WordBits; b++) begin
			for (int k = 0; k < BitW; k++) begin
				if (((b >> k) & 1) == 1) begin
					idx[k] = idx[k] | pick[b];
				end
			end
		end
		case (ctrl.action)
			ActLock, ActReserve: change = mask & ~word;
			ActFree, ActRelease: change = mask & word;
			ActRequest:          change = pick;
			default:             change = '0;
		endcase
		set_op = (ctrl.action != ActFree) && (ctrl.action != ActRelease);
		new_w  = set_op ? (word | change) : (word & ~change);
	end

	// population count tree of the changed bits
	always_comb begin
		for (int i = 0; i < 32; i++) p1[i] = 2'(change[2*i]) + 2'(change[2*i+1]);
		for (int i = 0; i < 16; i++) p2[i] = 3'(p1[2*i]) + 3'(p1[2*i+1]);
		for (int i = 0; i < 8; i++)  p3[i] = 4'(p2[2*i]) + 4'(p2[2*i+1]);
		for (int i = 0; i < 4; i++)  p4[i] = 5'(p3[2*i]) + 5'(p3[2*i+1]);
		for (int i = 0; i < 2; i++)  p5[i] = 6'(p4[2*i]) + 6'(p4[2*i+1]);
		pop = PopW'(p5[0]) + PopW'(p5[1]);
	end

	assign res = '{new_word: new_w, changed: pop, found: |avail, bit_idx: idx};

endmodule
`default_nettype wire

// ===== src/bitmap_page_frame_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bitmap page-frame allocator, first fit.
// Input channel (in_valid/in_ready) carries one command beat: action, page_index,
// page_count. Output channel (out_valid/out_ready) returns one result beat per
// command: status, granted_page and the three page counters after the command.
// The busy map lives in a synchronous RAM of 64-bit words, one read and one
// write per cycle. A command streams the words it covers through the RAM: one
// word read per cycle, modified and written back in the following cycle.
// After accept the sequencer works W map words in ST_RUN, then passes through
// ST_FIN and ST_DONE to the output register, where W is the number of map words
// covered by the in-range part of a run, or the words scanned by a request up to
// and including the one holding the first clear page. A command with nothing to
// touch goes straight to ST_FIN. One command is in flight at a time; the next
// beat can be taken once the result is registered. Reset, and every size write,
// starts a clearing pass that zeroes all MapWords map words (1024 at the default
// size); in_ready is low during it and the counters reload. If the receiver
// stalls, the result is held in the output register and a further command may
// be accepted and worked, but its result waits until the held beat is taken.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
	parameter int unsigned MAX_PAGES = MaxPagesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [15:0]       page_index,
	input  logic [CountW-1:0] page_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [15:0]       granted_page,
	output logic [CountW-1:0] avail_pages,
	output logic [CountW-1:0] used_pages,
	output logic [CountW-1:0] reserved_pages
);

	localparam int unsigned MapWords = (MAX_PAGES + 63) / 64;
	localparam int AddrW = (MapWords > 1) ? $clog2(MapWords) : 1;
	localparam logic [AddrW-1:0] LastAddr = AddrW'(MapWords - 1);
	// managed size never exceeds the store nor the register range
	localparam logic [CountW-1:0] CapSize =
		(MAX_PAGES > 131071) ? CountMax : CountW'(MAX_PAGES);
	localparam logic [CountW-1:0] ResetSize =
		(CapSize > 17'd65536) ? 17'd65536 : CapSize;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// busy map
	logic [WordBits-1:0] map_mem [MapWords];

	logic [2:0]        state_q;
	logic [AddrW-1:0]  clr_q;
	logic [CountW-1:0] total_q;
	logic [CountW-1:0] free_q;
	logic [CountW-1:0] used_q;
	logic [CountW-1:0] res_q;

	logic [2:0]        act_q;
	logic [WidxW-1:0]  first_q;
	logic [WidxW-1:0]  last_q;
	logic [BitW-1:0]   lo_q;
	logic [BitW-1:0]   hi_q;
	logic              oor_q;
	logic [WidxW-1:0]  rd_q;
	logic              issue_done_q;
	logic              found_q;
	logic [15:0]       granted_q;

	logic                v_s1;
	logic [WidxW-1:0]    w_s1;
	logic [WordBits-1:0] rdata_s1;
	logic                upd_s2;
	logic [PopW-1:0]     n_s2;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [15:0]       granted_out_q;
	logic [CountW-1:0] free_out_q;
	logic [CountW-1:0] used_out_q;
	logic [CountW-1:0] res_out_q;

	logic [CountW-1:0] size;
	logic [PageW-1:0]  size18;
	logic [PageW-1:0]  size_m1;
	logic [PageW-1:0]  end_pg;
	logic [PageW-1:0]  eff_end;
	logic [PageW-1:0]  eff_last;
	logic              oor;
	logic              work;
	logic [WidxW-1:0]  first_d;
	logic [WidxW-1:0]  last_d;
	logic [BitW-1:0]   lo_d;
	logic [BitW-1:0]   hi_d;
	logic              accept;

	logic              rd_en;
	logic              proc;
	logic              proc_end;
	logic              mem_we;
	logic [AddrW-1:0]  mem_wa;
	logic [WordBits-1:0] mem_wd;
	bpfa_ctrl_t        ctrl;
	bpfa_res_t         res;
	logic [15:0]       page_found;

	assign size     = (total_q > CapSize) ? CapSize : total_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// decode the command into a word range and edge bit positions
	always_comb begin
		size18   = PageW'(size);
		size_m1  = size18 - 18'd1;
		end_pg   = PageW'(page_index) + PageW'(page_count);
		oor      = (page_count != '0) && (end_pg > size18);
		eff_end  = oor ? size18 : end_pg;
		eff_last = eff_end - 18'd1;
		if (action == ActRequest) begin
			work    = (size != '0);
			first_d = '0;
			lo_d    = '0;
			last_d  = size_m1[PageW-1:BitW];
			hi_d    = size_m1[BitW-1:0];
		end else begin
			work    = (action inside {ActFree, ActLock, ActReserve, ActRelease})
				&& (eff_end > PageW'(page_index));
			first_d = WidxW'(page_index[15:BitW]);
			lo_d    = page_index[BitW-1:0];
			last_d  = eff_last[PageW-1:BitW];
			hi_d    = eff_last[BitW-1:0];
		end
	end

	assign rd_en = (state_q == ST_RUN) && !issue_done_q;
	assign proc  = v_s1 && (state_q == ST_RUN);

	always_comb begin
		ctrl.action = act_q;
		ctrl.lo     = (w_s1 == first_q) ? lo_q : '0;
		ctrl.hi     = (w_s1 == last_q) ? hi_q : '1;
	end

	bpfa_word_ops u_ops (
		.word (rdata_s1),
		.ctrl (ctrl),
		.res  (res)
	);

	assign page_found = 16'({w_s1, res.bit_idx});
	assign proc_end   = proc && ((w_s1 == last_q) || ((act_q == ActRequest) && res.found));

	always_comb begin
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = proc && (res.changed != '0);
			mem_wa = AddrW'(w_s1);
			mem_wd = res.new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= map_mem[AddrW'(rd_q)];
		w_s1     <= rd_q;
		n_s2     <= res.changed;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			total_q      <= 17'd65536;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			upd_s2       <= 1'b0;
			found_q      <= 1'b0;
			rd_q         <= '0;
		end else begin
			v_s1   <= rd_en;
			upd_s2 <= proc;
			if (cfg_we) begin
				total_q <= cfg_wdata;
				state_q <= ST_CLR;
				clr_q   <= '0;
			end else begin
				case (state_q)
					ST_CLR: begin
						if (clr_q == LastAddr) begin
							state_q <= ST_IDLE;
						end else begin
							clr_q <= clr_q + 1'b1;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							state_q      <= work ? ST_RUN : ST_FIN;
							rd_q         <= first_d;
							issue_done_q <= 1'b0;
							found_q      <= 1'b0;
						end
					end
					ST_RUN: begin
						if (rd_en) begin
							rd_q <= rd_q + 1'b1;
							if (rd_q == last_q) begin
								issue_done_q <= 1'b1;
							end
						end
						if (proc_end) begin
							state_q <= ST_FIN;
							found_q <= (act_q == ActRequest) && res.found;
						end
					end
					ST_FIN: begin
						state_q <= ST_DONE;
					end
					ST_DONE: begin
						if (!out_valid_q || out_ready) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// hold the command fields for the length of the command
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			first_q <= first_d;
			last_q  <= last_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			oor_q   <= oor && (action inside {ActFree, ActLock, ActReserve, ActRelease});
		end
		if (proc_end) begin
			granted_q <= page_found;
		end
	end

	// page counters: apply one word's worth of changes in the cycle after it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= ResetSize;
			used_q <= '0;
			res_q  <= '0;
		end else if (cfg_we) begin
			free_q <= (cfg_wdata > CapSize) ? CapSize : cfg_wdata;
			used_q <= '0;
			res_q  <= '0;
		end else if (upd_s2) begin
			case (act_q)
				ActLock, ActRequest: begin
					free_q <= sat_sub(free_q, n_s2);
					used_q <= sat_add(used_q, n_s2);
				end
				ActReserve: begin
					free_q <= sat_sub(free_q, n_s2);
					res_q  <= sat_add(res_q, n_s2);
				end
				ActFree: begin
					free_q <= sat_add(free_q, n_s2);
					used_q <= sat_sub(used_q, n_s2);
				end
				ActRelease: begin
					free_q <= sat_add(free_q, n_s2);
					res_q  <= sat_sub(res_q, n_s2);
				end
				default: begin
					free_q <= free_q;
				end
			endcase
		end
	end

	// output register: drop valid once taken, load when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			if (act_q == ActRequest) begin
				status_q <= found_q ? StDone : StNoFree;
			end else begin
				status_q <= oor_q ? StRange : StDone;
			end
			granted_out_q <= ((act_q == ActRequest) && found_q) ? granted_q : '0;
			free_out_q    <= free_q;
			used_out_q    <= used_q;
			res_out_q     <= res_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign granted_page   = granted_out_q;
	assign avail_pages    = free_out_q;
	assign used_pages     = used_out_q;
	assign reserved_pages = res_out_q;

endmodule
`default_nettype wire

// ===== src/bpfa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpfa_checker import bpfa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [15:0]       granted_page,
	input logic [CountW-1:0] avail_pages
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(granted_page) && $stable(avail_pages))
		else $error("result beat changed while stalled");

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in flight");

	// a size write starts the clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("commands taken during clearing pass");

	// a failed request hands out no page
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == StNoFree) |-> granted_page == '0)
		else $error("failed request returned a page");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
`default_nettype wire
